/* hdl/qlc_pkg.sv */
// qlc_pkg: word types and fixed constants for the quad load cell serial reader
// used by the core and by its checker, no dependencies
`default_nettype none

package qlc_pkg;

   localparam int NUM_CH = 4;
   localparam int FORCE_W = 16;

   localparam logic OPCODE_MEASURE = 1'b0;
   localparam logic OPCODE_TARE    = 1'b1;

   // exact unsigned divide of a 32 bit value by 1000 and by 5
   localparam logic [31:0] DIV1000_MAGIC = 32'h1062_4DD3;
   localparam int          DIV1000_SHIFT = 38;
   localparam logic [31:0] DIV5_MAGIC    = 32'hCCCC_CCCD;
   localparam int          DIV5_SHIFT    = 34;

   localparam logic [FORCE_W-1:0] FORCE_MAX = 16'hFFFF;

   typedef struct packed {
      logic opcode;
      logic bit_ch1;
      logic bit_ch2;
      logic bit_ch3;
      logic bit_ch4;
   } req_type;

   typedef struct packed {
      logic [FORCE_W-1:0] force_ch1;
      logic [FORCE_W-1:0] force_ch2;
      logic [FORCE_W-1:0] force_ch3;
      logic [FORCE_W-1:0] force_ch4;
   } rsp_type;

endpackage

`default_nettype wire

/* hdl/quad_load_cell_serial_reader_core.sv */
// quad_load_cell_serial_reader_core: four channel serial converter readout with tare
// depends on qlc_pkg
`default_nettype none

// One req word carries one serial bit per channel and is taken every cycle.
// After SAMPLE_BITS words a frame ends; its last opcode picks tare (store the
// four words as offsets, no rsp word) or measure (one rsp word). A measure
// result goes through three register stages after the frame's last bit:
// offset subtract, divide by 1000, scale by 2.2 with saturation, each in its
// own stage. Mid-frame words are always taken; a frame's last word is held off
// only while all three stages are full behind a stalled rsp word.
module quad_load_cell_serial_reader_core #(
   parameter int SAMPLE_BITS = 24
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  qlc_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output qlc_pkg::rsp_type rsp_data
);

   localparam int NCH = qlc_pkg::NUM_CH;
   localparam int FW  = qlc_pkg::FORCE_W;
   localparam int PW  = $clog2(SAMPLE_BITS);
   localparam int QW  = (SAMPLE_BITS > 9) ? SAMPLE_BITS - 9 : 1;
   localparam int RW  = QW + 2;
   localparam logic [SAMPLE_BITS-1:0] SIGN_FLIP = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

   logic [PW-1:0]          pos_ff, pos_in;
   logic [SAMPLE_BITS-2:0] shift_ff [NCH];
   logic [SAMPLE_BITS-2:0] shift_in [NCH];
   logic [SAMPLE_BITS-1:0] tare_ff  [NCH];
   logic [SAMPLE_BITS-1:0] word     [NCH];
   logic [SAMPLE_BITS-1:0] mag_ff   [NCH];
   logic [SAMPLE_BITS-1:0] mag_in   [NCH];
   logic [QW-1:0]          q_ff     [NCH];
   logic [QW-1:0]          q_in     [NCH];
   logic [63:0]            prod1    [NCH];
   logic [63:0]            prod2    [NCH];
   logic [RW-1:0]          scaled   [NCH];
   logic [FW-1:0]          force_ff [NCH];
   logic [FW-1:0]          force_in [NCH];
   logic                   s1_v_ff, s1_v_in;
   logic                   s2_v_ff;
   logic                   out_v_ff;
   logic [NCH-1:0]         bits;
   logic                   last, accept, is_tare;
   logic                   out_en, s2_en, s1_en;

   always_comb begin
      bits    = {req_data.bit_ch4, req_data.bit_ch3, req_data.bit_ch2, req_data.bit_ch1};
      last    = (pos_ff == PW'(SAMPLE_BITS - 1));
      is_tare = (req_data.opcode == qlc_pkg::OPCODE_TARE);

      out_en    = !out_v_ff || !rsp_stall;
      s2_en     = !s2_v_ff || out_en;
      s1_en     = !s1_v_ff || s2_en;
      req_stall = last && !s1_en;
      accept    = req_valid && !req_stall;

      pos_in  = last ? '0 : PW'(pos_ff + 1'b1);
      s1_v_in = accept && last && !is_tare;

      for (int ch = 0; ch < NCH; ch++) begin
         shift_in[ch] = last ? '0 : {shift_ff[ch][SAMPLE_BITS-3:0], bits[ch]};
         word[ch]     = {shift_ff[ch], bits[ch]} ^ SIGN_FLIP;
         mag_in[ch]   = (word[ch] >= tare_ff[ch]) ? word[ch] - tare_ff[ch]
                                                  : tare_ff[ch] - word[ch];

         prod1[ch] = 64'(mag_ff[ch]) * 64'(qlc_pkg::DIV1000_MAGIC);
         q_in[ch]  = prod1[ch][qlc_pkg::DIV1000_SHIFT +: QW];

         // floor(11q/5) = 2q + floor(q/5)
         prod2[ch]  = 64'(q_ff[ch]) * 64'(qlc_pkg::DIV5_MAGIC);
         scaled[ch] = RW'({q_ff[ch], 1'b0}) + RW'(prod2[ch][qlc_pkg::DIV5_SHIFT +: QW]);
         if (32'(scaled[ch]) > 32'(qlc_pkg::FORCE_MAX)) begin
            force_in[ch] = qlc_pkg::FORCE_MAX;
         end else begin
            force_in[ch] = FW'(scaled[ch]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff   <= '0;
         s1_v_ff  <= 1'b0;
         s2_v_ff  <= 1'b0;
         out_v_ff <= 1'b0;
         for (int ch = 0; ch < NCH; ch++) begin
            shift_ff[ch] <= '0;
            tare_ff[ch]  <= '0;
         end
      end else begin
         if (accept) begin
            pos_ff <= pos_in;
            for (int ch = 0; ch < NCH; ch++) begin
               shift_ff[ch] <= shift_in[ch];
               if (last && is_tare) begin
                  tare_ff[ch] <= word[ch];
               end
            end
         end
         if (s1_en) begin
            s1_v_ff <= s1_v_in;
         end
         if (s2_en) begin
            s2_v_ff <= s1_v_ff;
         end
         if (out_en) begin
            out_v_ff <= s2_v_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int ch = 0; ch < NCH; ch++) begin
         if (s1_en) begin
            mag_ff[ch] <= mag_in[ch];
         end
         if (s2_en) begin
            q_ff[ch] <= q_in[ch];
         end
         if (out_en) begin
            force_ff[ch] <= force_in[ch];
         end
      end
   end

   assign rsp_valid          = out_v_ff;
   assign rsp_data.force_ch1 = force_ff[0];
   assign rsp_data.force_ch2 = force_ff[1];
   assign rsp_data.force_ch3 = force_ff[2];
   assign rsp_data.force_ch4 = force_ff[3];

endmodule

`default_nettype wire

/* hdl/qlc_checker.sv */
// qlc_checker: port level assertions for the quad load cell serial reader core
// depends on qlc_pkg, bound to quad_load_cell_serial_reader_core
`default_nettype none

module qlc_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_stall,
   input qlc_pkg::req_type req_data,
   input logic             rsp_valid,
   input logic             rsp_stall,
   input qlc_pkg::rsp_type rsp_data
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("rsp word changed while stalled");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp valid after reset");

   a_stall_backpressure: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("req stalled without rsp back pressure");

   a_stall_needs_history: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> $past(rsp_valid))
      else $error("req stalled with empty pipeline");

endmodule

bind quad_load_cell_serial_reader_core qlc_checker u_qlc_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);

`default_nettype wire

/* sim/qlc_force_checker.sv */
// qlc_force_checker: watches all four channels of the quad load cell reader, predicts each force
// word from the accepted bit words and compares it field by field with what comes out
// depends on qlc_pkg
module qlc_force_checker
   import qlc_pkg::*;
#(
   parameter int SAMPLE_BITS = 24
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   input  logic    req_stall,
   input  req_type req_data,
   input  logic    rsp_valid,
   input  logic    rsp_stall,
   input  rsp_type rsp_data,
   output int      mismatch_count,
   output int      forces_due
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam longint unsigned COUNT_DIV = 1000;
   localparam longint unsigned SCALE_NUM = 11;
   localparam longint unsigned SCALE_DEN = 5;
   localparam logic [SAMPLE_BITS-1:0] SIGN_FLIP = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

   int                     errs = 0;
   int                     frame_pos = 0;
   logic [SAMPLE_BITS-1:0] shift_words [NUM_CH];
   logic [SAMPLE_BITS-1:0] tare_offsets [NUM_CH];
   rsp_type                force_queue [$];

   function automatic logic [FORCE_W-1:0] scaled_force(input logic [SAMPLE_BITS-1:0] word,
                                                       input logic [SAMPLE_BITS-1:0] offset);
      longint unsigned mag;
      longint unsigned scaled;
      mag = (word >= offset) ? longint'(word - offset) : longint'(offset - word);
      scaled = (mag / COUNT_DIV) * SCALE_NUM / SCALE_DEN;
      if (scaled > FORCE_MAX) begin
         scaled = FORCE_MAX;
      end
      return scaled[FORCE_W-1:0];
   endfunction

   always @(posedge clock) begin : watch
      logic [NUM_CH-1:0]  bits;
      logic [FORCE_W-1:0] want [NUM_CH];
      logic [FORCE_W-1:0] seen [NUM_CH];
      rsp_type            predicted;
      if (reset) begin
         frame_pos = 0;
         for (int c = 0; c < NUM_CH; c++) begin
            shift_words[c] = '0;
            tare_offsets[c] = '0;
         end
         force_queue.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (force_queue.size() == 0) begin
               errs++;
               if (errs <= 10) begin
                  $display("unexpected force word %h", rsp_data);
               end
            end else begin
               predicted = force_queue.pop_front();
               want = '{predicted.force_ch1, predicted.force_ch2,
                        predicted.force_ch3, predicted.force_ch4};
               seen = '{rsp_data.force_ch1, rsp_data.force_ch2,
                        rsp_data.force_ch3, rsp_data.force_ch4};
               for (int c = 0; c < NUM_CH; c++) begin
                  if (seen[c] !== want[c]) begin
                     errs++;
                     if (errs <= 10) begin
                        $display("force_ch%0d mismatch: expected %0d, got %0d",
                                 c + 1, want[c], seen[c]);
                     end
                  end
               end
            end
         end
         if (req_valid && !req_stall) begin
            bits = {req_data.bit_ch4, req_data.bit_ch3, req_data.bit_ch2, req_data.bit_ch1};
            for (int c = 0; c < NUM_CH; c++) begin
               shift_words[c] = {shift_words[c][SAMPLE_BITS-2:0], bits[c]};
            end
            if (frame_pos < SAMPLE_BITS - 1) begin
               frame_pos++;
            end else begin
               frame_pos = 0;
               for (int c = 0; c < NUM_CH; c++) begin
                  shift_words[c] = shift_words[c] ^ SIGN_FLIP;
               end
               if (req_data.opcode == OPCODE_TARE) begin
                  tare_offsets = shift_words;
               end else begin
                  predicted.force_ch1 = scaled_force(shift_words[0], tare_offsets[0]);
                  predicted.force_ch2 = scaled_force(shift_words[1], tare_offsets[1]);
                  predicted.force_ch3 = scaled_force(shift_words[2], tare_offsets[2]);
                  predicted.force_ch4 = scaled_force(shift_words[3], tare_offsets[3]);
                  force_queue.push_back(predicted);
               end
               for (int c = 0; c < NUM_CH; c++) begin
                  shift_words[c] = '0;
               end
            end
         end
      end
      mismatch_count <= errs;
      forces_due <= force_queue.size();
   end

endmodule

/* sim/quad_load_cell_serial_reader_core_test.sv */
// quad_load_cell_serial_reader_core_test: drives serial bit frames into the reader core with
// random idling and stalls, and gives the verdict from qlc_force_checker
// depends on qlc_pkg, quad_load_cell_serial_reader_core and qlc_force_checker
module quad_load_cell_serial_reader_core_test;
   timeunit 1ns;
   timeprecision 1ps;
   import qlc_pkg::*;

   localparam int SAMPLE_BITS   = 24;
   localparam int RANDOM_FRAMES = 46;
   localparam int MIN_MEASURES  = 36;
   localparam int PAUSE_FRAME   = 30;
   localparam int QUIET_FIRST   = 500;
   localparam int QUIET_LAST    = 760;
   localparam int HOLD_START    = 200;
   localparam int HOLD_END      = 500;
   localparam int STEADY_START  = 700;
   localparam int STEADY_END    = 1000;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;
   int      mismatch_count;
   int      forces_due;

   int                     words_sent = 0;
   int                     frames = 0;
   int                     measures = 0;
   logic [SAMPLE_BITS-1:0] frame_raw [NUM_CH];
   logic [SAMPLE_BITS-1:0] tare_raw [NUM_CH] = '{default: '0};

   quad_load_cell_serial_reader_core #(
      .SAMPLE_BITS(SAMPLE_BITS)
   ) uut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data(rsp_data)
   );

   qlc_force_checker #(
      .SAMPLE_BITS(SAMPLE_BITS)
   ) checker_i (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data(rsp_data),
      .mismatch_count(mismatch_count),
      .forces_due(forces_due)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   initial begin
      #200000;
      $display("Simulation FAILED");
      $finish;
   end

   task automatic send_word(input req_type w);
      while (!(words_sent >= QUIET_FIRST && words_sent < QUIET_LAST)
             && $urandom_range(99) < 15) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= w;
      @(posedge clock);
      while (req_stall) begin
         @(posedge clock);
      end
      words_sent++;
   endtask

   // msb first; only the last word's opcode counts, the others are random
   task automatic send_frame(input logic op);
      req_type w;
      for (int i = SAMPLE_BITS - 1; i >= 0; i--) begin
         w.opcode = (i == 0) ? op : 1'($urandom_range(1));
         w.bit_ch1 = frame_raw[0][i];
         w.bit_ch2 = frame_raw[1][i];
         w.bit_ch3 = frame_raw[2][i];
         w.bit_ch4 = frame_raw[3][i];
         send_word(w);
      end
   endtask

   function automatic logic [SAMPLE_BITS-1:0] pick_raw(input logic [SAMPLE_BITS-1:0] near);
      case ($urandom_range(7))
         0: return '0;
         1: return '1;
         2: return {1'b1, {(SAMPLE_BITS-1){1'b0}}};
         3: return {1'b0, {(SAMPLE_BITS-1){1'b1}}};
         4, 5: return SAMPLE_BITS'(near + $urandom_range(6000) - 3000);
         default: return SAMPLE_BITS'($urandom);
      endcase
   endfunction

   task automatic drain_forces();
      req_valid <= 1'b0;
      @(posedge clock);
      while (forces_due != 0) begin
         @(posedge clock);
      end
   endtask

   initial begin : receiver
      int cycle_no;
      cycle_no = 0;
      @(posedge clock);
      while (reset) begin
         @(posedge clock);
      end
      forever begin
         if (cycle_no >= HOLD_START && cycle_no < HOLD_END) begin
            rsp_stall <= 1'b1;
         end else if (cycle_no >= STEADY_START && cycle_no < STEADY_END) begin
            rsp_stall <= 1'b0;
         end else begin
            rsp_stall <= ($urandom_range(99) < 15);
         end
         @(posedge clock);
         cycle_no++;
      end
   end

   initial begin : stimulus
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // measure before any tare: full scale, zero, bare sign bit, largest flipped word
      frame_raw = '{'1, '0, {1'b1, {(SAMPLE_BITS-1){1'b0}}}, {1'b0, {(SAMPLE_BITS-1){1'b1}}}};
      send_frame(OPCODE_MEASURE);

      while (frames < RANDOM_FRAMES || measures < MIN_MEASURES) begin
         for (int c = 0; c < NUM_CH; c++) begin
            frame_raw[c] = pick_raw(tare_raw[c]);
         end
         if ($urandom_range(3) == 0) begin
            send_frame(OPCODE_TARE);
            tare_raw = frame_raw;
         end else begin
            send_frame(OPCODE_MEASURE);
            measures++;
         end
         frames++;
         if (frames == PAUSE_FRAME) begin
            drain_forces();
         end
      end

      drain_forces();
      repeat (8) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
